### design/dbpr_pkg.sv
// dbpr_pkg: shared widths, constants and types of the disparity bad pixel rate unit
// no dependencies; imported by every module of the block
`default_nettype none

package dbpr_pkg;

   localparam int MAX_PIXELS_LOG2 = 22;
   localparam int CNT_W           = MAX_PIXELS_LOG2;
   localparam int PCT_W           = 15;
   localparam int PROD_W          = CNT_W + PCT_W;
   localparam int STEP_W          = $clog2(PCT_W);
   localparam int NUM_REGIONS     = 3;
   localparam int REGION_W        = $clog2(NUM_REGIONS);
   localparam int QUEUE_DEPTH     = 4;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

   localparam logic [7:0]        MASK_ON    = 8'hFF;
   localparam logic [PCT_W-1:0]  FULL_SCALE = PCT_W'(25600);
   localparam logic [CNT_W-1:0]  COUNT_CAP  = {CNT_W{1'b1}};
   localparam logic [7:0]        THR_RESET  = 8'd1;

   localparam logic [REGION_W-1:0] REGION_ALL    = REGION_W'(0);
   localparam logic [REGION_W-1:0] REGION_DISC   = REGION_W'(1);
   localparam logic [REGION_W-1:0] REGION_NONOCC = REGION_W'(2);

   typedef struct packed {
      logic [NUM_REGIONS-1:0] in_region;
      logic                   bad;
      logic                   last;
   } pix_class_type;

endpackage

`default_nettype wire

### design/disparity_bad_pixel_rate_unit.sv
// Disparity bad pixel rate unit: a stream of pixels, one transaction each, is classified
// against the error threshold and counted per region (all, discontinuity, non-occluded).
// The front takes one pixel per cycle into a four-entry queue while the queue has room; the
// back counts one pixel per cycle while it is in its counting state. On the pixel marked last
// the back runs a shared restoring divider, a multiply step and then one divide step per
// quotient bit for each region, then loads the result register once any earlier result
// is taken, raising rsp_valid; the queue backs up meanwhile. Counts saturate at 2^22 - 1.
// depends on dbpr_pkg, dbpr_front, dbpr_queue, dbpr_back
`default_nettype none

module disparity_bad_pixel_rate_unit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [7:0]             csr_wr_data,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [7:0]             req_true_disparity,
   input  wire logic [7:0]             req_est_disparity,
   input  wire logic [7:0]             req_mask_all_byte,
   input  wire logic [7:0]             req_mask_disc_byte,
   input  wire logic [7:0]             req_mask_nonocc_byte,
   input  wire logic                   req_last_pixel,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [dbpr_pkg::PCT_W-1:0]  rsp_pct_all,
   output logic [dbpr_pkg::PCT_W-1:0]  rsp_pct_disc,
   output logic [dbpr_pkg::PCT_W-1:0]  rsp_pct_nonocc,
   output logic                        rsp_all_valid,
   output logic                        rsp_disc_valid,
   output logic                        rsp_nonocc_valid
);
   import dbpr_pkg::*;

   logic          f_valid, f_ready;
   pix_class_type f_data;
   logic          b_valid, b_ready;
   pix_class_type b_data;

   dbpr_front u_front (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_true_disparity   (req_true_disparity),
      .req_est_disparity    (req_est_disparity),
      .req_mask_all_byte    (req_mask_all_byte),
      .req_mask_disc_byte   (req_mask_disc_byte),
      .req_mask_nonocc_byte (req_mask_nonocc_byte),
      .req_last_pixel       (req_last_pixel),
      .cls_valid            (f_valid),
      .cls_ready            (f_ready),
      .cls_data             (f_data)
   );

   dbpr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_data  (b_data)
   );

   dbpr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cls_valid        (b_valid),
      .cls_ready        (b_ready),
      .cls_data         (b_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pct_all      (rsp_pct_all),
      .rsp_pct_disc     (rsp_pct_disc),
      .rsp_pct_nonocc   (rsp_pct_nonocc),
      .rsp_all_valid    (rsp_all_valid),
      .rsp_disc_valid   (rsp_disc_valid),
      .rsp_nonocc_valid (rsp_nonocc_valid)
   );

endmodule

`default_nettype wire

### design/dbpr_front.sv
// dbpr_front: holds the error threshold, accepts pixels and classifies them
// depends on dbpr_pkg
`default_nettype none

module dbpr_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [7:0]             csr_wr_data,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [7:0]             req_true_disparity,
   input  wire logic [7:0]             req_est_disparity,
   input  wire logic [7:0]             req_mask_all_byte,
   input  wire logic [7:0]             req_mask_disc_byte,
   input  wire logic [7:0]             req_mask_nonocc_byte,
   input  wire logic                   req_last_pixel,
   output logic                        cls_valid,
   input  wire logic                   cls_ready,
   output dbpr_pkg::pix_class_type     cls_data
);
   import dbpr_pkg::*;

   logic [7:0]    thr_ff, thr_in;
   logic          cls_valid_ff, cls_valid_in;
   pix_class_type cls_ff, cls_in;
   logic [7:0]    diff;
   logic          take;

   always_comb begin
      req_ready = !cls_valid_ff || cls_ready;
      take      = req_valid && req_ready;
      thr_in    = csr_wr_en ? csr_wr_data : thr_ff;

      if (req_true_disparity >= req_est_disparity) begin
         diff = req_true_disparity - req_est_disparity;
      end else begin
         diff = req_est_disparity - req_true_disparity;
      end

      cls_in                   = cls_ff;
      if (take) begin
         cls_in.in_region[REGION_ALL]    = (req_mask_all_byte == MASK_ON);
         cls_in.in_region[REGION_DISC]   = (req_mask_disc_byte == MASK_ON);
         cls_in.in_region[REGION_NONOCC] = (req_mask_nonocc_byte == MASK_ON);
         cls_in.bad                      = (diff > thr_ff);
         cls_in.last                     = req_last_pixel;
      end

      if (take) begin
         cls_valid_in = 1'b1;
      end else if (cls_ready) begin
         cls_valid_in = 1'b0;
      end else begin
         cls_valid_in = cls_valid_ff;
      end

      cls_valid = cls_valid_ff;
      cls_data  = cls_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THR_RESET;
         cls_valid_ff <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         cls_valid_ff <= cls_valid_in;
      end
      cls_ff <= cls_in;
   end

endmodule

`default_nettype wire

### design/dbpr_queue.sv
// dbpr_queue: small transaction queue between the classifying front and the counting back
// depends on dbpr_pkg
`default_nettype none

module dbpr_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire dbpr_pkg::pix_class_type in_data,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output dbpr_pkg::pix_class_type     out_data
);
   import dbpr_pkg::*;

   pix_class_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              push, pop;

   always_comb begin
      in_ready  = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
      out_valid = (count_ff != '0);
      push      = in_valid && in_ready;
      pop       = out_ready && out_valid;
      out_data  = entry_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + (QPTR_W+1)'(1);
         2'b01:   count_in = count_ff - (QPTR_W+1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

### design/dbpr_back.sv
// dbpr_back: per-region counters, end-of-image restoring divider and result register
// depends on dbpr_pkg
`default_nettype none

module dbpr_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   cls_valid,
   output logic                        cls_ready,
   input  wire dbpr_pkg::pix_class_type cls_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [dbpr_pkg::PCT_W-1:0]  rsp_pct_all,
   output logic [dbpr_pkg::PCT_W-1:0]  rsp_pct_disc,
   output logic [dbpr_pkg::PCT_W-1:0]  rsp_pct_nonocc,
   output logic                        rsp_all_valid,
   output logic                        rsp_disc_valid,
   output logic                        rsp_nonocc_valid
);
   import dbpr_pkg::*;

   localparam logic [1:0] ST_COUNT = 2'd0;
   localparam logic [1:0] ST_MUL   = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [1:0] ST_HOLD  = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [CNT_W-1:0]       tot_ff [NUM_REGIONS];
   logic [CNT_W-1:0]       tot_in [NUM_REGIONS];
   logic [CNT_W-1:0]       bad_ff [NUM_REGIONS];
   logic [CNT_W-1:0]       bad_in [NUM_REGIONS];
   logic [PCT_W-1:0]       pct_ff [NUM_REGIONS];
   logic [NUM_REGIONS-1:0] nz_ff;
   logic [REGION_W-1:0]    reg_ff, reg_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [CNT_W-1:0]       rem_ff, rem_in;
   logic [PCT_W-1:0]       quo_ff, quo_in;
   logic [PROD_W-1:0]      prod;
   logic [CNT_W:0]         rem_shift;
   logic                   ge;
   logic [CNT_W-1:0]       cur_tot;
   logic                   pop, store, load;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PCT_W-1:0]       rsp_pct_ff [NUM_REGIONS];
   logic [NUM_REGIONS-1:0] rsp_nz_ff;

   always_comb begin
      cls_ready = (state_ff == ST_COUNT);
      pop       = cls_valid && cls_ready;
      cur_tot   = tot_ff[reg_ff];
      prod      = PROD_W'(bad_ff[reg_ff]) * PROD_W'(FULL_SCALE);
      rem_shift = {rem_ff, quo_ff[PCT_W-1]};
      ge        = (rem_shift >= {1'b0, cur_tot});
      store     = (state_ff == ST_DIV) && (step_ff == STEP_W'(PCT_W-1));
      load      = (state_ff == ST_HOLD) && (!rsp_valid_ff || rsp_ready);

      state_in = state_ff;
      reg_in   = reg_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;

      for (int r = 0; r < NUM_REGIONS; r++) begin
         tot_in[r] = tot_ff[r];
         bad_in[r] = bad_ff[r];
         if (load) begin
            tot_in[r] = '0;
            bad_in[r] = '0;
         end else if (pop && cls_data.in_region[r]) begin
            if (tot_ff[r] != COUNT_CAP) begin
               tot_in[r] = tot_ff[r] + CNT_W'(1);
            end
            if (cls_data.bad && (bad_ff[r] != COUNT_CAP)) begin
               bad_in[r] = bad_ff[r] + CNT_W'(1);
            end
         end
      end

      case (state_ff)
         ST_COUNT: begin
            if (pop && cls_data.last) begin
               state_in = ST_MUL;
               reg_in   = REGION_ALL;
            end
         end
         ST_MUL: begin
            rem_in   = prod[PROD_W-1:PCT_W];
            quo_in   = prod[PCT_W-1:0];
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = ge ? CNT_W'(rem_shift - {1'b0, cur_tot}) : rem_shift[CNT_W-1:0];
            quo_in  = {quo_ff[PCT_W-2:0], ge};
            step_in = step_ff + STEP_W'(1);
            if (store) begin
               if (reg_ff == REGION_NONOCC) begin
                  state_in = ST_HOLD;
               end else begin
                  reg_in   = reg_ff + REGION_W'(1);
                  state_in = ST_MUL;
               end
            end
         end
         ST_HOLD: begin
            if (load) begin
               state_in = ST_COUNT;
            end
         end
         default: state_in = ST_COUNT;
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      rsp_valid        = rsp_valid_ff;
      rsp_pct_all      = rsp_pct_ff[REGION_ALL];
      rsp_pct_disc     = rsp_pct_ff[REGION_DISC];
      rsp_pct_nonocc   = rsp_pct_ff[REGION_NONOCC];
      rsp_all_valid    = rsp_nz_ff[REGION_ALL];
      rsp_disc_valid   = rsp_nz_ff[REGION_DISC];
      rsp_nonocc_valid = rsp_nz_ff[REGION_NONOCC];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COUNT;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < NUM_REGIONS; r++) begin
            tot_ff[r] <= '0;
            bad_ff[r] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int r = 0; r < NUM_REGIONS; r++) begin
            tot_ff[r] <= tot_in[r];
            bad_ff[r] <= bad_in[r];
         end
      end
      reg_ff  <= reg_in;
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      if (store) begin
         pct_ff[reg_ff] <= (cur_tot != '0) ? quo_in : '0;
         nz_ff[reg_ff]  <= (cur_tot != '0);
      end
      if (load) begin
         for (int r = 0; r < NUM_REGIONS; r++) begin
            rsp_pct_ff[r] <= pct_ff[r];
         end
         rsp_nz_ff <= nz_ff;
      end
   end

`ifndef ASSERT_OFF
   a_bad_le_total: assert property (@(posedge clock) disable iff (reset)
      (bad_ff[REGION_ALL] <= tot_ff[REGION_ALL]) &&
      (bad_ff[REGION_DISC] <= tot_ff[REGION_DISC]) &&
      (bad_ff[REGION_NONOCC] <= tot_ff[REGION_NONOCC]))
      else $error("bad count above region total");
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      store |-> (quo_in <= FULL_SCALE) || (cur_tot == '0))
      else $error("percentage above full scale");
   a_clear_on_load: assert property (@(posedge clock) disable iff (reset)
      load |=> (tot_ff[REGION_ALL] == '0) && (tot_ff[REGION_DISC] == '0) &&
               (tot_ff[REGION_NONOCC] == '0) && rsp_valid_ff)
      else $error("counters not cleared after result");
`endif

endmodule

`default_nettype wire
